/* rtl/periodic_timer_table_unit_defines.svh */
// Assertion macros for the periodic timer table.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PERIODIC_TIMER_TABLE_UNIT_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define PTT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("periodic timer table: check failed");

// next-cycle implication, off during reset
`define PTT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("periodic timer table: check failed");

`endif

/* rtl/ptt_pkg.sv */
// Shared types and constants of the periodic timer table.
// No dependencies; used by every module of the block but ptt_ram.
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int NUM_TIMERS  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W       = $clog2(NUM_TIMERS + 1);
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
    localparam int ROW_W       = 24;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_CREATE  = 3'd1;
    localparam logic [2:0] CMD_ENABLE  = 3'd2;
    localparam logic [2:0] CMD_DISABLE = 3'd3;
    localparam logic [2:0] CMD_DELETE  = 3'd4;

    localparam logic [1:0] KIND_CREATE    = 2'd0;
    localparam logic [1:0] KIND_ACK       = 2'd1;
    localparam logic [1:0] KIND_EXPIRY    = 2'd2;
    localparam logic [1:0] KIND_TICK_IDLE = 2'd3;

    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    typedef struct packed {
        logic [2:0] command;
        logic [3:0] slot;
        logic       no_handle;
        logic [7:0] reload_ticks;
        logic       start_enabled;
        logic [7:0] callback_arg;
        logic       has_handler;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       status;
        logic [3:0] result_slot;
        logic [7:0] expired_arg;
        logic       last;
    } res_item_t;

    typedef enum logic [1:0] {
        OPC_TICK   = 2'd0,
        OPC_CREATE = 2'd1,
        OPC_CTL    = 2'd2,
        OPC_BAD    = 2'd3
    } op_cls_t;

    // decoded request as queued between front and back
    typedef struct packed {
        op_cls_t    cls;
        logic [2:0] command;
        logic       ok;
        logic [3:0] slot;
        logic [7:0] reload;
        logic       start_en;
        logic [7:0] arg;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } op_head_t;

    typedef struct packed {
        logic      push;
        res_item_t item;
    } res_push_t;

endpackage

/* rtl/ptt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ptt_front.sv */
// Front end: accepts requests, classifies them and queues the decoded ops.
// Depends on ptt_pkg.
`timescale 1ns / 1ps

module ptt_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  ptt_pkg::in_item_t  req,
    output ptt_pkg::op_head_t  op_q,
    input  logic               op_pop
);

    ptt_pkg::op_t dec;
    ptt_pkg::op_t q_reg [2];
    logic         rd_ptr_reg, rd_ptr_next;
    logic         wr_ptr_reg, wr_ptr_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         do_push;
    logic         do_pop;
    logic         slot_in_range;

    assign slot_in_range = (32'(req.slot) < ptt_pkg::NUM_TIMERS);

    always_comb
    begin
        dec.command  = req.command;
        dec.slot     = req.slot;
        dec.reload   = req.reload_ticks;
        dec.start_en = req.start_enabled;
        dec.arg      = req.callback_arg;
        case (req.command)
            ptt_pkg::CMD_TICK:
            begin
                dec.cls = ptt_pkg::OPC_TICK;
                dec.ok  = 1'b1;
            end
            ptt_pkg::CMD_CREATE:
            begin
                dec.cls = ptt_pkg::OPC_CREATE;
                dec.ok  = !req.no_handle && req.has_handler && (req.reload_ticks != 8'd0);
            end
            ptt_pkg::CMD_ENABLE, ptt_pkg::CMD_DISABLE, ptt_pkg::CMD_DELETE:
            begin
                dec.cls = ptt_pkg::OPC_CTL;
                dec.ok  = !req.no_handle && slot_in_range;
            end
            default:
            begin
                dec.cls = ptt_pkg::OPC_BAD;
                dec.ok  = 1'b0;
            end
        endcase
    end

    assign full       = (cnt_reg == 2'd2);
    assign do_push    = push && !full;
    assign do_pop     = op_pop && (cnt_reg != 2'd0);
    assign op_q.valid = (cnt_reg != 2'd0);
    assign op_q.op    = q_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

/* rtl/ptt_back.sv */
// Back end: slot table state, create/control execution and the tick scan.
// Depends on ptt_pkg and ptt_ram.
`timescale 1ns / 1ps

module ptt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ptt_pkg::op_head_t   op_q,
    output logic                op_pop,
    output ptt_pkg::res_push_t  res_push,
    input  logic                res_ready
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CREATE = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINAL  = 4'b1000
    } back_state_t;

    localparam int N = ptt_pkg::NUM_TIMERS;
    localparam int IW = ptt_pkg::IDX_W;
    localparam int CW = ptt_pkg::CNT_W;
    localparam int NW = ptt_pkg::NRES_W;

    back_state_t          state_reg, state_next;
    logic [N-1:0]         in_use_reg, in_use_next;
    logic [N-1:0]         enabled_reg, enabled_next;
    logic [N-1:0]         written_reg, written_next;
    logic [CW-1:0]        rd_idx_reg, rd_idx_next;
    logic [IW-1:0]        p_idx_reg, p_idx_next;
    logic                 pv_reg, pv_next;
    logic                 hv_reg, hv_next;
    logic [IW-1:0]        hslot_reg, hslot_next;
    logic [7:0]           harg_reg, harg_next;
    logic [NW-1:0]        n_reg, n_next;
    logic [IW-1:0]        free_idx_reg;
    logic                 free_ok_reg;
    logic [IW-1:0]        free_idx;
    logic                 free_any;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [ptt_pkg::ROW_W-1:0] ram_wdata;
    logic [IW-1:0]        ram_raddr;
    logic [ptt_pkg::ROW_W-1:0] ram_rdata;
    logic [ptt_pkg::ROW_W-1:0] row_eff;

    logic [7:0]           p_cnt, p_rel, p_arg, p_dec;
    logic                 p_en, p_hit, p_event, scan_adv;
    logic [IW-1:0]        op_sidx;

    ptt_ram #(
        .WIDTH (ptt_pkg::ROW_W),
        .DEPTH (N)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // lowest free slot, registered; in_use settles while a create waits in ST_IDLE, before ST_CREATE uses it
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_idx = IW'(i);
                free_any = 1'b1;
            end
        end
    end

    // never-written rows read as their reset value of zero
    assign row_eff = written_reg[p_idx_reg] ? ram_rdata : '0;
    assign p_cnt   = row_eff[23:16];
    assign p_rel   = row_eff[15:8];
    assign p_arg   = row_eff[7:0];
    assign p_dec   = p_cnt - 8'd1;
    assign p_hit   = (p_dec == 8'd0);
    assign p_en    = enabled_reg[p_idx_reg];
    assign p_event = pv_reg && p_en && p_hit && in_use_reg[p_idx_reg]
                     && (n_reg < NW'(ptt_pkg::MAX_RESULTS));
    // a new expiry flushes the held one; hold the scan if there is no room
    assign scan_adv = !(p_event && hv_reg && !res_ready);

    // on a stall, re-read the slot being processed so its data stays put
    assign ram_raddr = ((state_reg == ST_SCAN) && !scan_adv) ? p_idx_reg
                                                             : rd_idx_reg[IW-1:0];

    assign op_sidx = IW'(op_q.op.slot);

    always_comb
    begin
        state_next   = state_reg;
        in_use_next  = in_use_reg;
        enabled_next = enabled_reg;
        written_next = written_reg;
        rd_idx_next  = rd_idx_reg;
        p_idx_next   = p_idx_reg;
        pv_next      = pv_reg;
        hv_next      = hv_reg;
        hslot_next   = hslot_reg;
        harg_next    = harg_reg;
        n_next       = n_reg;
        op_pop       = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = p_idx_reg;
        ram_wdata    = '0;
        res_push     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (op_q.valid)
                begin
                    case (op_q.op.cls)
                        ptt_pkg::OPC_TICK:
                        begin
                            op_pop      = 1'b1;
                            rd_idx_next = '0;
                            pv_next     = 1'b0;
                            hv_next     = 1'b0;
                            n_next      = '0;
                            state_next  = ST_SCAN;
                        end
                        ptt_pkg::OPC_CREATE:
                        begin
                            state_next = ST_CREATE;
                        end
                        ptt_pkg::OPC_CTL:
                        begin
                            if (res_ready)
                            begin
                                op_pop                = 1'b1;
                                res_push.push         = 1'b1;
                                res_push.item.kind    = ptt_pkg::KIND_ACK;
                                res_push.item.last    = 1'b1;
                                res_push.item.status  = op_q.op.ok ? ptt_pkg::STAT_OK
                                                                   : ptt_pkg::STAT_ERR;
                                if (op_q.op.ok)
                                begin
                                    case (op_q.op.command)
                                        ptt_pkg::CMD_ENABLE:
                                        begin
                                            enabled_next[op_sidx] = 1'b1;
                                        end
                                        ptt_pkg::CMD_DISABLE:
                                        begin
                                            enabled_next[op_sidx] = 1'b0;
                                        end
                                        ptt_pkg::CMD_DELETE:
                                        begin
                                            enabled_next[op_sidx] = 1'b0;
                                            in_use_next[op_sidx]  = 1'b0;
                                        end
                                        default:
                                        begin
                                        end
                                    endcase
                                end
                            end
                        end
                        default:
                        begin
                            if (res_ready)
                            begin
                                op_pop               = 1'b1;
                                res_push.push        = 1'b1;
                                res_push.item.kind   = ptt_pkg::KIND_ACK;
                                res_push.item.status = ptt_pkg::STAT_ERR;
                                res_push.item.last   = 1'b1;
                            end
                        end
                    endcase
                end
            end

            ST_CREATE:
            begin
                if (res_ready)
                begin
                    op_pop             = 1'b1;
                    res_push.push      = 1'b1;
                    res_push.item.kind = ptt_pkg::KIND_CREATE;
                    res_push.item.last = 1'b1;
                    if (op_q.op.ok && free_ok_reg)
                    begin
                        in_use_next[free_idx_reg]  = 1'b1;
                        enabled_next[free_idx_reg] = op_q.op.start_en;
                        written_next[free_idx_reg] = 1'b1;
                        ram_we                     = 1'b1;
                        ram_waddr                  = free_idx_reg;
                        ram_wdata = {op_q.op.reload, op_q.op.reload, op_q.op.arg};
                        res_push.item.status      = ptt_pkg::STAT_OK;
                        res_push.item.result_slot = 4'(free_idx_reg);
                    end
                    else
                    begin
                        res_push.item.status = ptt_pkg::STAT_ERR;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (scan_adv)
                begin
                    if (pv_reg && p_en)
                    begin
                        ram_we                  = 1'b1;
                        ram_waddr               = p_idx_reg;
                        ram_wdata               = {(p_hit ? p_rel : p_dec), p_rel, p_arg};
                        written_next[p_idx_reg] = 1'b1;
                    end
                    if (p_event)
                    begin
                        if (hv_reg)
                        begin
                            res_push.push             = 1'b1;
                            res_push.item.kind        = ptt_pkg::KIND_EXPIRY;
                            res_push.item.status      = ptt_pkg::STAT_OK;
                            res_push.item.result_slot = 4'(hslot_reg);
                            res_push.item.expired_arg = harg_reg;
                        end
                        hv_next    = 1'b1;
                        hslot_next = p_idx_reg;
                        harg_next  = p_arg;
                        n_next     = n_reg + NW'(1);
                    end
                    if (rd_idx_reg < CW'(N))
                    begin
                        pv_next     = 1'b1;
                        p_idx_next  = rd_idx_reg[IW-1:0];
                        rd_idx_next = rd_idx_reg + CW'(1);
                    end
                    else
                    begin
                        pv_next    = 1'b0;
                        state_next = ST_FINAL;
                    end
                end
            end

            ST_FINAL:
            begin
                if (res_ready)
                begin
                    res_push.push      = 1'b1;
                    res_push.item.last = 1'b1;
                    if (hv_reg)
                    begin
                        res_push.item.kind        = ptt_pkg::KIND_EXPIRY;
                        res_push.item.status      = ptt_pkg::STAT_OK;
                        res_push.item.result_slot = 4'(hslot_reg);
                        res_push.item.expired_arg = harg_reg;
                    end
                    else
                    begin
                        res_push.item.kind   = ptt_pkg::KIND_TICK_IDLE;
                        res_push.item.status = ptt_pkg::STAT_OK;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            in_use_reg  <= '0;
            enabled_reg <= '0;
            written_reg <= '0;
            rd_idx_reg  <= '0;
            pv_reg      <= 1'b0;
            hv_reg      <= 1'b0;
            n_reg       <= '0;
            free_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            in_use_reg  <= in_use_next;
            enabled_reg <= enabled_next;
            written_reg <= written_next;
            rd_idx_reg  <= rd_idx_next;
            pv_reg      <= pv_next;
            hv_reg      <= hv_next;
            n_reg       <= n_next;
            free_ok_reg <= free_any;
        end
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg    <= p_idx_next;
        hslot_reg    <= hslot_next;
        harg_reg     <= harg_next;
        free_idx_reg <= free_idx;
    end

endmodule

/* rtl/ptt_resq.sv */
// Two-entry result queue between the back end and the result ports.
// Depends on ptt_pkg.
`timescale 1ns / 1ps

module ptt_resq (
    input  logic                clk,
    input  logic                rst_n,
    input  ptt_pkg::res_push_t  res_in,
    output logic                ready,
    output logic                empty,
    input  logic                pop,
    output ptt_pkg::res_item_t  res
);

    ptt_pkg::res_item_t q_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign ready   = (cnt_reg != 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign res     = q_reg[rd_ptr_reg];
    assign do_push = res_in.push && ready;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= res_in.item;
        end
    end

endmodule

/* rtl/periodic_timer_table_unit.sv */
// Periodic timer table, top level: front end, back end and result queue.
// Depends on ptt_pkg, ptt_front, ptt_back, ptt_resq and the defines header.
//
// A table of NUM_TIMERS periodic timers driven by tick, create, enable,
// disable and delete requests, with a queue interface on both sides (two
// request entries in, two result entries out). Enable, disable, delete and
// unknown commands are answered from the idle state of the back end, create
// from a further state (the lowest free slot is looked up from a registered
// priority encoder). A tick walks the slot RAM one slot per cycle, unless
// the result side stalls, through its single read port. Expiry events come
// out in slot order with the final result of each request marked by last.
// The slot RAM needs no clearing pass after reset: a per-slot written flag
// makes untouched rows read as zero.
`timescale 1ns / 1ps
`include "periodic_timer_table_unit_defines.svh"

module periodic_timer_table_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  ptt_pkg::in_item_t   req,
    output logic                empty,
    input  logic                pop,
    output ptt_pkg::res_item_t  res
);

    ptt_pkg::op_head_t  op_q;
    logic               op_pop;
    ptt_pkg::res_push_t res_push;
    logic               res_ready;

    ptt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .req    (req),
        .op_q   (op_q),
        .op_pop (op_pop)
    );

    ptt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_q      (op_q),
        .op_pop    (op_pop),
        .res_push  (res_push),
        .res_ready (res_ready)
    );

    ptt_resq u_resq (
        .clk    (clk),
        .rst_n  (rst_n),
        .res_in (res_push),
        .ready  (res_ready),
        .empty  (empty),
        .pop    (pop),
        .res    (res)
    );

    `PTT_ASSERT_IMPL(a_res_no_overflow, res_push.push, res_ready)
    `PTT_ASSERT_IMPL(a_pop_has_op, op_pop, op_q.valid)
    `PTT_ASSERT_IMPL(a_idle_tick_last, !empty && res.kind == ptt_pkg::KIND_TICK_IDLE,
                     res.last && res.status == ptt_pkg::STAT_OK)
    `PTT_ASSERT_NEXT(a_push_not_empty_later, res_push.push && res_ready, !empty)

endmodule
